[sv/ght_pkg.sv]
package ght_pkg;

   localparam int OPCODE_W = 2;
   localparam int SLOT_W   = 4;
   localparam int VALUE_W  = 32;
   localparam int SEED_W   = 16;
   localparam int STATUS_W = 2;

   localparam logic [OPCODE_W-1:0] OP_ALLOC     = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_RECYCLE   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_LOOKUP    = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_READ_SEED = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_SCAN   = 6'b000100,
      S_DRAIN  = 6'b001000,
      S_LATCH  = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

endpackage

[sv/ght_store.sv]
module ght_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 48,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/generational_handle_table_core.sv]
// Lookup, recycle, read seed and the first allocate after reset pass S_IDLE, S_LATCH and
// S_FINISH; a slot out of range goes from S_IDLE to S_FINISH; a later allocate scans one
// slot per cycle in S_SCAN through the one read port of the store, then S_DRAIN, S_FINISH.
// S_FINISH holds while the output is stalled. One request in flight; req_stall drops as the
// result is registered, so the next request transfers only after S_FINISH hands it over.
// Reset (synchronous, active high) starts a pass through S_CLEAR that zeroes every value and seed.
module generational_handle_table_core #(
   parameter int SLOTS      = 16,
   parameter int VALUE_BITS = 32,
   parameter int SEED_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ght_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [ght_pkg::SLOT_W-1:0]    req_slot_in,
   input  logic [ght_pkg::VALUE_W-1:0]   req_value_in,
   input  logic [ght_pkg::SEED_W-1:0]    req_seed_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ght_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ght_pkg::SLOT_W-1:0]    rsp_slot_out,
   output logic [ght_pkg::VALUE_W-1:0]   rsp_value_out,
   output logic [ght_pkg::SEED_W-1:0]    rsp_seed_out
);
   import ght_pkg::*;

   localparam int AW     = $clog2(SLOTS);
   localparam int WORD_W = SEED_BITS + VALUE_BITS;
   localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

   state_type state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic chk_ff, chk_in;
   logic [AW-1:0] chk_idx_ff, chk_idx_in;
   logic [AW-1:0] tgt_ff, tgt_in;
   logic found_ff, found_in;
   logic started_ff, started_in;
   logic in_range_ff, in_range_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [SEED_W-1:0] seed_ff, seed_in;
   logic [VALUE_BITS-1:0] cur_val_ff, cur_val_in;
   logic [SEED_BITS-1:0] cur_seed_ff, cur_seed_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [SEED_W-1:0] rsp_seed_ff, rsp_seed_in;

   logic mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [WORD_W-1:0] mem_wdata, mem_rdata;
   logic [VALUE_BITS-1:0] rd_val;
   logic [SEED_BITS-1:0] rd_seed;

   logic [31:0] req_slot_wide;
   logic [AW-1:0] req_idx;
   logic req_in_range;
   logic req_fire;
   logic out_free;
   logic scan_hit;

   logic [SEED_BITS-1:0] seed_inc;
   logic [31:0] cur_seed_wide, seed_inc_wide, tgt_wide;
   logic [63:0] cur_val_wide, store_val_wide;
   logic seed_match;

   logic [STATUS_W-1:0] fin_status;
   logic [SLOT_W-1:0] fin_slot;
   logic [VALUE_W-1:0] fin_value;
   logic [SEED_W-1:0] fin_seed;
   logic fin_write;
   logic [WORD_W-1:0] fin_word;

   ght_store #(
      .DEPTH (SLOTS),
      .WIDTH (WORD_W),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rd_val  = mem_rdata[VALUE_BITS-1:0];
   assign rd_seed = mem_rdata[WORD_W-1:VALUE_BITS];

   assign req_slot_wide = 32'(req_slot_in);
   assign req_idx       = req_slot_wide[AW-1:0];
   assign req_in_range  = req_slot_wide < 32'(SLOTS);
   assign req_stall     = (state_ff != S_IDLE);
   assign req_fire      = req_valid && !req_stall;
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign scan_hit      = chk_ff && (rd_val == '0);

   assign seed_inc       = cur_seed_ff + SEED_BITS'(1);
   assign cur_seed_wide  = 32'(cur_seed_ff);
   assign seed_inc_wide  = 32'(seed_inc);
   assign tgt_wide       = 32'(tgt_ff);
   assign cur_val_wide   = 64'(cur_val_ff);
   assign store_val_wide = 64'(value_ff);
   assign seed_match     = (cur_seed_wide == 32'(seed_ff));

   always_comb begin
      fin_status = ST_OK;
      fin_slot   = slot_ff;
      fin_value  = '0;
      fin_seed   = cur_seed_wide[SEED_W-1:0];
      fin_write  = 1'b0;
      fin_word   = {cur_seed_ff, store_val_wide[VALUE_BITS-1:0]};
      if (op_ff == OP_ALLOC) begin
         if (found_ff) begin
            fin_slot  = tgt_wide[SLOT_W-1:0];
            fin_write = 1'b1;
         end else begin
            fin_status = ST_FULL;
            fin_slot   = '0;
            fin_seed   = '0;
         end
      end else if (!in_range_ff) begin
         fin_status = (op_ff == OP_LOOKUP) ? ST_STALE : ST_OK;
         fin_seed   = '0;
      end else begin
         case (op_ff)
            OP_RECYCLE: begin
               fin_write = 1'b1;
               fin_word  = {seed_inc, {VALUE_BITS{1'b0}}};
               fin_seed  = seed_inc_wide[SEED_W-1:0];
            end
            OP_LOOKUP: begin
               if (seed_match) begin
                  fin_value = cur_val_wide[VALUE_W-1:0];
               end else begin
                  fin_status = ST_STALE;
               end
            end
            default: begin
               fin_seed = cur_seed_wide[SEED_W-1:0];
            end
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      chk_in        = 1'b0;
      chk_idx_in    = cnt_ff;
      tgt_in        = tgt_ff;
      found_in      = found_ff;
      started_in    = started_ff;
      in_range_in   = in_range_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      value_in      = value_ff;
      seed_in       = seed_ff;
      cur_val_in    = cur_val_ff;
      cur_seed_in   = cur_seed_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_seed_in   = rsp_seed_ff;
      mem_we        = 1'b0;
      mem_waddr     = tgt_ff;
      mem_wdata     = fin_word;
      mem_raddr     = tgt_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = '0;
            cnt_in    = cnt_ff + AW'(1);
            if (cnt_ff == LAST) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            mem_raddr = (req_opcode == OP_ALLOC) ? '0 : req_idx;
            if (req_fire) begin
               op_in       = req_opcode;
               slot_in     = req_slot_in;
               value_in    = req_value_in;
               seed_in     = req_seed_in;
               in_range_in = req_in_range;
               if (req_opcode == OP_ALLOC) begin
                  if (!started_ff) begin
                     started_in = 1'b1;
                     found_in   = 1'b1;
                     tgt_in     = '0;
                     state_in   = S_LATCH;
                  end else begin
                     found_in = 1'b0;
                     cnt_in   = '0;
                     state_in = S_SCAN;
                  end
               end else begin
                  tgt_in   = req_idx;
                  state_in = req_in_range ? S_LATCH : S_FINISH;
               end
            end
         end
         S_SCAN: begin
            mem_raddr  = cnt_ff;
            chk_in     = 1'b1;
            chk_idx_in = cnt_ff;
            cnt_in     = cnt_ff + AW'(1);
            if (scan_hit) begin
               found_in    = 1'b1;
               tgt_in      = chk_idx_ff;
               cur_seed_in = rd_seed;
            end
            if (cnt_ff == LAST) begin
               cnt_in   = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (scan_hit) begin
               found_in    = 1'b1;
               tgt_in      = chk_idx_ff;
               cur_seed_in = rd_seed;
            end
            state_in = S_FINISH;
         end
         S_LATCH: begin
            cur_val_in  = rd_val;
            cur_seed_in = rd_seed;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               mem_we        = fin_write;
               rsp_valid_in  = 1'b1;
               rsp_status_in = fin_status;
               rsp_slot_in   = fin_slot;
               rsp_value_in  = fin_value;
               rsp_seed_in   = fin_seed;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chk_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_ff       <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff    <= chk_idx_in;
      tgt_ff        <= tgt_in;
      found_ff      <= found_in;
      in_range_ff   <= in_range_in;
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      value_ff      <= value_in;
      seed_ff       <= seed_in;
      cur_val_ff    <= cur_val_in;
      cur_seed_ff   <= cur_seed_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_seed_ff   <= rsp_seed_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_slot_out  = rsp_slot_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_seed_out  = rsp_seed_ff;

endmodule

[sv/ght_checker.sv]
module ght_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [ght_pkg::STATUS_W-1:0]  rsp_status,
   input logic [ght_pkg::SLOT_W-1:0]    rsp_slot_out,
   input logic [ght_pkg::VALUE_W-1:0]   rsp_value_out,
   input logic [ght_pkg::SEED_W-1:0]    rsp_seed_out
);
   import ght_pkg::*;

   a_reset_drops_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous one in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) &&
         $stable(rsp_slot_out) && $stable(rsp_value_out) && $stable(rsp_seed_out)))
      else $error("stalled result changed");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |->
         (rsp_slot_out == '0 && rsp_seed_out == '0 && rsp_value_out == '0))
      else $error("full status with nonzero fields");

   a_stale_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_STALE) |-> (rsp_value_out == '0))
      else $error("stale status with payload");

endmodule

bind generational_handle_table_core ght_checker u_ght_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_slot_out  (rsp_slot_out),
   .rsp_value_out (rsp_value_out),
   .rsp_seed_out  (rsp_seed_out)
);

[tb/tb_generational_handle_table_core.sv]
`timescale 1ns / 1ps

module tb_generational_handle_table_core;
   import ght_pkg::*;

   localparam int NSLOTS = 16;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [VALUE_W-1:0]  value;
      logic [SEED_W-1:0]   seed;
   } handle_rsp_type;

   typedef struct {
      logic [OPCODE_W-1:0] op;
      logic [SLOT_W-1:0]   slot;
      logic [VALUE_W-1:0]  value;
      logic [SEED_W-1:0]   seed;
      bit                  typed;
      handle_rsp_type      want;
   } handle_req_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OPCODE_W-1:0] req_opcode = OP_READ_SEED;
   logic [SLOT_W-1:0]   req_slot_in = '0;
   logic [VALUE_W-1:0]  req_value_in = '0;
   logic [SEED_W-1:0]   req_seed_in = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_out;
   logic [VALUE_W-1:0]  rsp_value_out;
   logic [SEED_W-1:0]   rsp_seed_out;

   logic [VALUE_W-1:0] value_of [NSLOTS];
   logic [SEED_W-1:0]  seed_of [NSLOTS];
   bit                 table_started = 1'b0;

   handle_rsp_type pending_rsps [$];
   handle_req_type directed_rows [$];
   handle_req_type cur_req;
   bit             quiet = 1'b0;
   int             accept_count = 0;
   int             error_count = 0;
   int             rsp_count = 0;
   int             full_count = 0;
   int             stale_count = 0;

   generational_handle_table_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_slot_in   (req_slot_in),
      .req_value_in  (req_value_in),
      .req_seed_in   (req_seed_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_slot_out  (rsp_slot_out),
      .rsp_value_out (rsp_value_out),
      .rsp_seed_out  (rsp_seed_out)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("tb_generational_handle_table_core: errors");
      $finish;
   end

   function automatic handle_rsp_type apply_handle_op(input logic [OPCODE_W-1:0] op,
                                                     input logic [SLOT_W-1:0] slot,
                                                     input logic [VALUE_W-1:0] value,
                                                     input logic [SEED_W-1:0] seed);
      handle_rsp_type r;
      int             pick;
      bit             found;
      r.status = ST_OK;
      r.slot   = slot;
      r.value  = '0;
      r.seed   = '0;
      pick     = 0;
      found    = 1'b0;
      case (op)
         OP_ALLOC: begin
            if (!table_started) begin
               table_started = 1'b1;
               found = 1'b1;
            end else begin
               for (int i = 0; i < NSLOTS; i++)
                  if (value_of[i] == '0) begin
                     pick = i;
                     found = 1'b1;
                  end
            end
            if (!found) begin
               r.status = ST_FULL;
               r.slot   = '0;
            end else begin
               value_of[pick] = value;
               r.slot = pick[SLOT_W-1:0];
               r.seed = seed_of[pick];
            end
         end
         OP_RECYCLE: begin
            value_of[slot] = '0;
            seed_of[slot]  = seed_of[slot] + 1'b1;
            r.seed = seed_of[slot];
         end
         OP_LOOKUP: begin
            r.seed = seed_of[slot];
            if (seed_of[slot] != seed)
               r.status = ST_STALE;
            else
               r.value = value_of[slot];
         end
         default: begin
            r.seed = seed_of[slot];
         end
      endcase
      return r;
   endfunction

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         $display("%0t rsp_%s mismatch: expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      handle_rsp_type want;
      handle_rsp_type model;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (rsp_status == ST_FULL) full_count++;
            if (rsp_status == ST_STALE) stale_count++;
            if (pending_rsps.size() == 0) begin
               $display("%0t unexpected transfer: status %0h slot %0h value %0h seed %0h",
                        $time, rsp_status, rsp_slot_out, rsp_value_out, rsp_seed_out);
               error_count++;
            end else begin
               want = pending_rsps.pop_front();
               report_field("status", 32'(want.status), 32'(rsp_status));
               report_field("slot_out", 32'(want.slot), 32'(rsp_slot_out));
               report_field("value_out", 32'(want.value), 32'(rsp_value_out));
               report_field("seed_out", 32'(want.seed), 32'(rsp_seed_out));
            end
         end
         if (req_valid && !req_stall) begin
            model = apply_handle_op(req_opcode, req_slot_in, req_value_in, req_seed_in);
            if (cur_req.typed)
               pending_rsps.push_back(cur_req.want);
            else
               pending_rsps.push_back(model);
            accept_count <= accept_count + 1;
         end
      end
   end

   always @(negedge clock)
      rsp_stall <= !quiet && ($urandom_range(99) < 12);

   task automatic send_request(input handle_req_type r);
      int seen;
      while (!quiet && ($urandom_range(99) < 12)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      cur_req = r;
      req_valid    <= 1'b1;
      req_opcode   <= r.op;
      req_slot_in  <= r.slot;
      req_value_in <= r.value;
      req_seed_in  <= r.seed;
      seen = accept_count;
      do @(negedge clock); while (accept_count == seen);
   endtask

   task automatic add_row(input logic [OPCODE_W-1:0] op, input logic [SLOT_W-1:0] slot,
                          input logic [VALUE_W-1:0] value, input logic [SEED_W-1:0] seed,
                          input bit typed, input logic [STATUS_W-1:0] st,
                          input logic [SLOT_W-1:0] wslot, input logic [VALUE_W-1:0] wvalue,
                          input logic [SEED_W-1:0] wseed);
      handle_req_type r;
      r.op = op;
      r.slot = slot;
      r.value = value;
      r.seed = seed;
      r.typed = typed;
      r.want.status = st;
      r.want.slot = wslot;
      r.want.value = wvalue;
      r.want.seed = wseed;
      directed_rows.push_back(r);
   endtask

   initial begin
      handle_req_type r;
      int             alloc_bias;
      int             roll;
      for (int i = 0; i < NSLOTS; i++) begin
         value_of[i] = '0;
         seed_of[i]  = '0;
      end

      add_row(OP_LOOKUP, 4'd0, 32'h0, 16'h0, 1'b1, ST_OK, 4'd0, 32'h0, 16'h0);
      add_row(OP_READ_SEED, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, ST_OK, 4'd15, 32'h0, 16'h0);
      add_row(OP_LOOKUP, 4'd3, 32'h0, 16'hFFFF, 1'b1, ST_STALE, 4'd3, 32'h0, 16'h0);
      add_row(OP_ALLOC, 4'd7, 32'hFFFF_FFFF, 16'h0, 1'b1, ST_OK, 4'd0, 32'h0, 16'h0);
      add_row(OP_ALLOC, 4'd0, 32'h0, 16'h0, 1'b1, ST_OK, 4'd15, 32'h0, 16'h0);
      add_row(OP_ALLOC, 4'd0, 32'h1, 16'h0, 1'b1, ST_OK, 4'd15, 32'h0, 16'h0);
      for (int i = 0; i < NSLOTS - 2; i++)
         add_row(OP_ALLOC, 4'(i), 32'h8000_0000 >> i, 16'(i), 1'b0, ST_OK, 4'd0, 32'h0,
                 16'h0);
      add_row(OP_ALLOC, 4'd15, 32'h1234_5678, 16'h0, 1'b1, ST_FULL, 4'd0, 32'h0, 16'h0);
      add_row(OP_RECYCLE, 4'd0, 32'h0, 16'h0, 1'b1, ST_OK, 4'd0, 32'h0, 16'h1);
      add_row(OP_LOOKUP, 4'd0, 32'h0, 16'h0, 1'b1, ST_STALE, 4'd0, 32'h0, 16'h1);
      add_row(OP_RECYCLE, 4'd0, 32'h0, 16'h0, 1'b1, ST_OK, 4'd0, 32'h0, 16'h2);
      add_row(OP_LOOKUP, 4'd0, 32'h0, 16'h2, 1'b1, ST_OK, 4'd0, 32'h0, 16'h2);
      add_row(OP_LOOKUP, 4'd15, 32'h0, 16'h0, 1'b0, ST_OK, 4'd0, 32'h0, 16'h0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i]);

      alloc_bias = 30;
      for (int k = 0; k < 470; k++) begin
         quiet = (k >= 200) && (k < 300);
         if (k % 60 == 0)
            alloc_bias = $urandom_range(10, 60);
         r.typed  = 1'b0;
         r.slot   = 4'($urandom_range(NSLOTS - 1));
         r.value  = $urandom;
         r.seed   = 16'($urandom_range(16'hFFFF));
         roll = $urandom_range(99);
         if (roll < alloc_bias) begin
            r.op = OP_ALLOC;
            roll = $urandom_range(99);
            if (roll < 6)
               r.value = '0;
            else if (roll < 10)
               r.value = '1;
         end else begin
            roll = $urandom_range(99);
            if (roll < 30)
               r.op = OP_RECYCLE;
            else if (roll < 80)
               r.op = OP_LOOKUP;
            else
               r.op = OP_READ_SEED;
            roll = $urandom_range(99);
            if (roll < 70)
               r.seed = seed_of[r.slot];
            else if (roll < 85)
               r.seed = seed_of[r.slot] ^ (16'h1 << $urandom_range(SEED_W - 1));
         end
         send_request(r);
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (pending_rsps.size() != 0)
         @(negedge clock);
      repeat (NSLOTS + 8) @(negedge clock);

      $display("checked %0d result transfers after %0d request transfers", rsp_count,
               accept_count);
      $display("full-table results: %0d, stale-seed results: %0d", full_count, stale_count);
      if (error_count == 0 && pending_rsps.size() == 0)
         $display("tb_generational_handle_table_core: clean");
      else
         $display("tb_generational_handle_table_core: errors");
      $finish;
   end

endmodule
